// ----- src/imm_pkg.sv -----
package imm_pkg;

    // defaults for the top-level parameters
    localparam int MAX_DIM_DEF    = 8;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed field widths
    localparam int OP_W        = 2;
    localparam int IDX_W       = 3;
    localparam int VAL_W       = 32;
    localparam int CFG_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    // command queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int KIND_W     = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd2;

    // opcodes on the input stream
    localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
    localparam logic [OP_W-1:0] OP_START  = 2'd2;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 2'd3;

    typedef enum logic [KIND_W-1:0] {
        CMD_LOAD_A,
        CMD_LOAD_B,
        CMD_START
    } t_cmd;

    // effective matrix sizes, already clamped to 1..MAX_DIM
    typedef struct packed {
        logic [CFG_W-1:0] a_rows;
        logic [CFG_W-1:0] a_cols;
        logic [CFG_W-1:0] b_rows;
        logic [CFG_W-1:0] b_cols;
    } t_dims;

    function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v,
                                                 input int max_dim);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (int'(v) > max_dim) begin
            r = CFG_W'(max_dim);
        end
        return r;
    endfunction

endpackage

// ----- src/imm_front.sv -----
module imm_front #(
    parameter int MAX_DIM    = imm_pkg::MAX_DIM_DEF,
    parameter int DATA_WIDTH = imm_pkg::DATA_WIDTH_DEF,
    parameter int ADDR_W     = 6,
    parameter int CMD_W      = DATA_WIDTH + ADDR_W + imm_pkg::KIND_W
) (
    input  logic                            i_tvalid,
    output logic                            o_tready,
    input  logic [imm_pkg::IN_TDATA_W-1:0]  i_tdata,
    input  imm_pkg::t_dims                  i_dims,
    input  logic                            i_q_full,
    output logic                            o_push,
    output logic [CMD_W-1:0]                o_cmd
);

    logic [imm_pkg::OP_W-1:0]         op;
    logic [imm_pkg::IDX_W-1:0]        row;
    logic [imm_pkg::IDX_W-1:0]        col;
    logic signed [imm_pkg::VAL_W-1:0] val;
    logic                             in_a;
    logic                             in_b;
    logic                             keep;
    imm_pkg::t_cmd                    kind;
    logic [ADDR_W-1:0]                addr;

    assign op  = i_tdata[1:0];
    assign row = i_tdata[4:2];
    assign col = i_tdata[7:5];
    assign val = i_tdata[39:8];

    assign in_a = ({1'b0, row} < i_dims.a_rows) && ({1'b0, col} < i_dims.a_cols);
    assign in_b = ({1'b0, row} < i_dims.b_rows) && ({1'b0, col} < i_dims.b_cols);

    // loads outside the sizes and the unused opcode are dropped here
    always_comb begin
        case (op)
            imm_pkg::OP_LOAD_A: begin
                keep = in_a;
                kind = imm_pkg::CMD_LOAD_A;
            end
            imm_pkg::OP_LOAD_B: begin
                keep = in_b;
                kind = imm_pkg::CMD_LOAD_B;
            end
            imm_pkg::OP_START: begin
                keep = 1'b1;
                kind = imm_pkg::CMD_START;
            end
            default: begin
                keep = 1'b0;
                kind = imm_pkg::CMD_START;
            end
        endcase
    end

    assign addr = ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col);

    assign o_tready = !i_q_full;
    assign o_push   = i_tvalid && o_tready && keep;
    assign o_cmd    = {DATA_WIDTH'(val), addr, kind};

endmodule

// ----- src/imm_fifo.sv -----
module imm_fifo #(
    parameter int WIDTH = 40
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);

    localparam int PW = imm_pkg::FIFO_PTR_W;

    logic [WIDTH-1:0] r_mem [imm_pkg::FIFO_DEPTH];
    logic [PW:0]      r_wr;
    logic [PW:0]      r_rd;

    assign o_empty = (r_wr == r_rd);
    assign o_full  = (r_wr[PW] != r_rd[PW]) && (r_wr[PW-1:0] == r_rd[PW-1:0]);
    assign o_data  = r_mem[r_rd[PW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr[PW-1:0]] <= i_data;
        end
    end

endmodule

// ----- src/imm_back.sv -----
module imm_back #(
    parameter int MAX_DIM    = imm_pkg::MAX_DIM_DEF,
    parameter int DATA_WIDTH = imm_pkg::DATA_WIDTH_DEF,
    parameter int ADDR_W     = 6,
    parameter int CMD_W      = DATA_WIDTH + ADDR_W + imm_pkg::KIND_W
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  imm_pkg::t_dims                   i_dims,
    input  logic                             i_q_empty,
    input  logic [CMD_W-1:0]                 i_q_data,
    output logic                             o_q_pop,
    input  logic                             i_tready,
    output logic                             o_tvalid,
    output logic [imm_pkg::OUT_TDATA_W-1:0]  o_tdata,
    output logic                             o_tlast,
    output logic [0:0]                       o_tuser
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int HW    = (DATA_WIDTH + 1) / 2;
    localparam int LW    = DATA_WIDTH - HW;
    localparam int CW    = imm_pkg::CFG_W;
    localparam int PAD_W = imm_pkg::OUT_TDATA_W - imm_pkg::VAL_W - 2 * imm_pkg::IDX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_ERR
    } t_state;

    t_state                           r_state;
    logic [CW-1:0]                    r_i;
    logic [CW-1:0]                    r_j;
    logic [CW-1:0]                    r_k;

    logic [DATA_WIDTH-1:0]            r_a_mem [DEPTH];
    logic [DATA_WIDTH-1:0]            r_b_mem [DEPTH];
    logic [DATA_WIDTH-1:0]            r_a_q;
    logic [DATA_WIDTH-1:0]            r_b_q;

    logic                             r_s1_v, r_s1_first, r_s1_last;
    logic                             r_s2_v, r_s2_first, r_s2_last;
    logic [DATA_WIDTH-1:0]            r_pp0;
    logic [LW-1:0]                    r_pp1;
    logic [LW-1:0]                    r_pp2;
    logic [DATA_WIDTH-1:0]            r_acc;
    logic                             r_done;

    logic                             r_out_valid;
    logic [imm_pkg::IDX_W-1:0]        r_out_row;
    logic [imm_pkg::IDX_W-1:0]        r_out_col;
    logic [imm_pkg::VAL_W-1:0]        r_out_val;
    logic                             r_out_last;
    logic                             r_out_err;

    imm_pkg::t_cmd                    kind;
    logic [ADDR_W-1:0]                waddr;
    logic [DATA_WIDTH-1:0]            wval;
    logic [ADDR_W-1:0]                a_raddr;
    logic [ADDR_W-1:0]                b_raddr;
    logic                             k_last;
    logic                             j_last;
    logic                             i_last;
    logic                             out_free;
    logic                             consume;
    logic                             out_load;
    logic signed [DATA_WIDTH-1:0]     acc_s;
    logic [2*HW-1:0]                  m0;
    logic [HW+LW-1:0]                 m1;
    logic [HW+LW-1:0]                 m2;

    assign kind  = imm_pkg::t_cmd'(i_q_data[imm_pkg::KIND_W-1:0]);
    assign waddr = i_q_data[ADDR_W+imm_pkg::KIND_W-1:imm_pkg::KIND_W];
    assign wval  = i_q_data[CMD_W-1:ADDR_W+imm_pkg::KIND_W];

    assign o_q_pop = (r_state == S_IDLE) && !i_q_empty;

    assign a_raddr = ADDR_W'(r_i) * ADDR_W'(MAX_DIM) + ADDR_W'(r_k);
    assign b_raddr = ADDR_W'(r_k) * ADDR_W'(MAX_DIM) + ADDR_W'(r_j);

    assign k_last = (r_k == i_dims.a_cols - 1'b1);
    assign j_last = (r_j == i_dims.b_cols - 1'b1);
    assign i_last = (r_i == i_dims.a_rows - 1'b1);

    assign out_free = !r_out_valid || i_tready;
    assign consume  = (r_state == S_DRAIN) && r_done && out_free;
    // output register takes a new item this cycle
    assign out_load = consume || ((r_state == S_ERR) && out_free);
    assign acc_s    = r_acc;

    // element stores, one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (o_q_pop && kind == imm_pkg::CMD_LOAD_A) begin
            r_a_mem[waddr] <= wval;
        end
        if (o_q_pop && kind == imm_pkg::CMD_LOAD_B) begin
            r_b_mem[waddr] <= wval;
        end
        r_a_q <= r_a_mem[a_raddr];
        r_b_q <= r_b_mem[b_raddr];
    end

    // low DATA_WIDTH bits of the product from half-width partial products
    assign m0 = r_a_q[HW-1:0] * r_b_q[HW-1:0];
    assign m1 = r_a_q[HW-1:0] * r_b_q[DATA_WIDTH-1:HW];
    assign m2 = r_a_q[DATA_WIDTH-1:HW] * r_b_q[HW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_s1_v <= (r_state == S_ISSUE);
            r_s2_v <= r_s1_v;
            if (consume) begin
                r_done <= 1'b0;
            end else if (r_s2_v && r_s2_last) begin
                r_done <= 1'b1;
            end
        end
        r_s1_first <= (r_k == '0);
        r_s1_last  <= k_last;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_pp0      <= m0[DATA_WIDTH-1:0];
        r_pp1      <= m1[LW-1:0];
        r_pp2      <= m2[LW-1:0];
        if (r_s2_v) begin
            r_acc <= (r_s2_first ? '0 : r_acc) + r_pp0 + {r_pp1 + r_pp2, {HW{1'b0}}};
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
        end else begin
            if (i_tready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop && kind == imm_pkg::CMD_START) begin
                        r_i <= '0;
                        r_j <= '0;
                        r_k <= '0;
                        if (i_dims.a_cols != i_dims.b_rows) begin
                            r_state <= S_ERR;
                        end else begin
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_ISSUE: begin
                    if (k_last) begin
                        r_k     <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (consume) begin
                        r_out_valid <= 1'b1;
                        r_out_row   <= r_i[imm_pkg::IDX_W-1:0];
                        r_out_col   <= r_j[imm_pkg::IDX_W-1:0];
                        r_out_val   <= imm_pkg::VAL_W'(acc_s);
                        r_out_last  <= i_last && j_last;
                        r_out_err   <= 1'b0;
                        if (i_last && j_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_ISSUE;
                            if (j_last) begin
                                r_j <= '0;
                                r_i <= r_i + 1'b1;
                            end else begin
                                r_j <= r_j + 1'b1;
                            end
                        end
                    end
                end
                S_ERR: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_row   <= '0;
                        r_out_col   <= '0;
                        r_out_val   <= '0;
                        r_out_last  <= 1'b1;
                        r_out_err   <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = {{PAD_W{1'b0}}, r_out_val, r_out_col, r_out_row};
    assign o_tlast  = r_out_last;
    assign o_tuser  = r_out_err;

endmodule

// ----- src/integer_matrix_multiply_top.sv -----
// Channel   Dir  Handshake                       Payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata: opcode, row_index, col_index,
//                                                 element_value
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata: out_row, out_col, product_value;
//                                                 tlast: is_last; tuser: size_error
// cfg       in   i_cfg_valid/o_cfg_ready          i_cfg_index, i_cfg_data
//
// Input items enter a four-deep command queue at one per cycle while it has room; the
// back end retires one load per cycle while it is idle. A start leaves the queue, then
// each product element runs a_cols multiply-accumulate issues followed by the store
// read, multiply and accumulate stages, then waits for room in the output register.
// Synchronous active-low reset clears control state and sets all sizes to 2, not the stores.
// A stalled output holds its item; the queue keeps taking loads meanwhile until it is full.
module integer_matrix_multiply_top #(
    parameter int MAX_DIM    = imm_pkg::MAX_DIM_DEF,
    parameter int DATA_WIDTH = imm_pkg::DATA_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // [1:0] opcode, [4:2] row_index, [7:5] col_index, [39:8] element_value
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [imm_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // [2:0] out_row, [5:3] out_col, [37:6] product_value, [39:38] zero
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [imm_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    output logic                             o_m_axis_tlast,
    // [0] size_error
    output logic [0:0]                       o_m_axis_tuser,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [imm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [imm_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMD_W  = DATA_WIDTH + ADDR_W + imm_pkg::KIND_W;

    logic [imm_pkg::CFG_W-1:0] r_a_rows;
    logic [imm_pkg::CFG_W-1:0] r_a_cols;
    logic [imm_pkg::CFG_W-1:0] r_b_rows;
    logic [imm_pkg::CFG_W-1:0] r_b_cols;
    imm_pkg::t_dims            dims;

    logic                      q_push;
    logic                      q_pop;
    logic                      q_empty;
    logic                      q_full;
    logic [CMD_W-1:0]          q_wdata;
    logic [CMD_W-1:0]          q_rdata;

    // size registers; a write lands at once, so it belongs between runs
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows <= imm_pkg::CFG_RESET;
            r_a_cols <= imm_pkg::CFG_RESET;
            r_b_rows <= imm_pkg::CFG_RESET;
            r_b_cols <= imm_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                imm_pkg::REG_A_ROWS: r_a_rows <= i_cfg_data;
                imm_pkg::REG_A_COLS: r_a_cols <= i_cfg_data;
                imm_pkg::REG_B_ROWS: r_b_rows <= i_cfg_data;
                imm_pkg::REG_B_COLS: r_b_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // zero acts as one, anything above MAX_DIM as MAX_DIM
    assign dims.a_rows = imm_pkg::eff_dim(r_a_rows, MAX_DIM);
    assign dims.a_cols = imm_pkg::eff_dim(r_a_cols, MAX_DIM);
    assign dims.b_rows = imm_pkg::eff_dim(r_b_rows, MAX_DIM);
    assign dims.b_cols = imm_pkg::eff_dim(r_b_cols, MAX_DIM);

    imm_front #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH),
        .ADDR_W     (ADDR_W),
        .CMD_W      (CMD_W)
    ) u_front (
        .i_tvalid (i_s_axis_tvalid),
        .o_tready (o_s_axis_tready),
        .i_tdata  (i_s_axis_tdata),
        .i_dims   (dims),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (q_wdata)
    );

    imm_fifo #(
        .WIDTH (CMD_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    imm_back #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH),
        .ADDR_W     (ADDR_W),
        .CMD_W      (CMD_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_dims    (dims),
        .i_q_empty (q_empty),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_pop),
        .i_tready  (i_m_axis_tready),
        .o_tvalid  (o_m_axis_tvalid),
        .o_tdata   (o_m_axis_tdata),
        .o_tlast   (o_m_axis_tlast),
        .o_tuser   (o_m_axis_tuser)
    );

    // a size error item is always the only and last item of its start
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tlast &&
            (o_m_axis_tdata[37:6] == '0))
        else $error("size error item without tlast or with nonzero product");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("command popped from empty queue");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full && !q_pop |=> !q_empty)
        else $error("queue lost items while full");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid straight after reset");

endmodule
